/* src/m4te_pkg.sv */
`timescale 1ns / 1ps

package m4te_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int STEP_W    = 6;
    localparam int IDX_W     = 4;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 128;
    localparam int S_TUSER_W = 3;
    localparam int M_TUSER_W = 1;

    localparam logic signed [DATA_W-1:0] Q_ONE   = DATA_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [STEP_W-1:0] COMPOSE_LAST_STEP = STEP_W'(63);
    localparam logic [STEP_W-1:0] PASS_LAST_STEP    = STEP_W'(15);
    localparam logic [IDX_W-1:0]  XFORM_LAST_RES    = IDX_W'(3);
    localparam logic [IDX_W-1:0]  MATRIX_LAST_RES   = IDX_W'(15);

    typedef enum logic [2:0] {
        ACT_WR_M    = 3'd0,
        ACT_WR_B    = 3'd1,
        ACT_COMPOSE = 3'd2,
        ACT_SCALE   = 3'd3,
        ACT_XFORM   = 3'd4,
        ACT_RD_M    = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              ready;
        logic              issue_vld;
        logic              first;
        logic              last;
        logic [STEP_W-1:0] step;
        logic [IDX_W-1:0]  ridx;
        logic              load_out;
        t_action           op;
    } t_seq_ctl;

endpackage

/* src/m4te_mac.sv */
`timescale 1ns / 1ps

module m4te_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    input  logic                                   i_first,
    input  logic                                   i_last,
    input  logic signed [m4te_pkg::DATA_W-1:0]     i_a,
    input  logic signed [m4te_pkg::DATA_W-1:0]     i_b,
    output logic                                   o_vld,
    output logic signed [m4te_pkg::DATA_W-1:0]     o_res,
    output logic                                   o_sat
);

    logic signed [m4te_pkg::PROD_W-1:0] r_prod;
    logic                               r_vld1;
    logic                               r_first1;
    logic                               r_last1;
    logic signed [m4te_pkg::ACC_W-1:0]  r_acc;
    logic signed [m4te_pkg::ACC_W-1:0]  n_acc;
    logic                               r_done;
    logic signed [m4te_pkg::ACC_W-1:0]  w_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_done <= r_vld1 && r_last1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= i_a * i_b;
        r_first1 <= i_first;
        r_last1  <= i_last;
        if (r_vld1) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        if (r_first1) begin
            n_acc = m4te_pkg::ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + m4te_pkg::ACC_W'(r_prod);
        end
    end

    assign w_shift = r_acc >>> m4te_pkg::FRAC_BITS;

    always_comb begin
        o_vld = r_done;
        if (w_shift > m4te_pkg::ACC_W'(m4te_pkg::SAT_MAX)) begin
            o_res = m4te_pkg::SAT_MAX;
            o_sat = 1'b1;
        end else if (w_shift < m4te_pkg::ACC_W'(m4te_pkg::SAT_MIN)) begin
            o_res = m4te_pkg::SAT_MIN;
            o_sat = 1'b1;
        end else begin
            o_res = w_shift[m4te_pkg::DATA_W-1:0];
            o_sat = 1'b0;
        end
    end

endmodule

/* src/m4te_seq.sv */
`timescale 1ns / 1ps

module m4te_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  m4te_pkg::t_action           i_op,
    input  logic                        i_res_vld,
    input  logic                        i_out_free,
    output m4te_pkg::t_seq_ctl          o_ctl
);

    m4te_pkg::t_state                   r_state;
    m4te_pkg::t_state                   n_state;
    m4te_pkg::t_action                  r_op;
    m4te_pkg::t_action                  n_op;
    logic [m4te_pkg::STEP_W-1:0]        r_step;
    logic [m4te_pkg::STEP_W-1:0]        n_step;
    logic [m4te_pkg::IDX_W-1:0]         r_ridx;
    logic [m4te_pkg::IDX_W-1:0]         n_ridx;
    logic [m4te_pkg::STEP_W-1:0]        w_last_step;
    logic [m4te_pkg::IDX_W-1:0]         w_last_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= m4te_pkg::ST_IDLE;
            r_op    <= m4te_pkg::ACT_WR_M;
            r_step  <= '0;
            r_ridx  <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_step  <= n_step;
            r_ridx  <= n_ridx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_step  = r_step;
        n_ridx  = r_ridx;

        w_last_step = (r_op == m4te_pkg::ACT_COMPOSE) ? m4te_pkg::COMPOSE_LAST_STEP
                                                      : m4te_pkg::PASS_LAST_STEP;
        w_last_res  = (r_op == m4te_pkg::ACT_XFORM) ? m4te_pkg::XFORM_LAST_RES
                                                    : m4te_pkg::MATRIX_LAST_RES;

        o_ctl           = '0;
        o_ctl.step      = r_step;
        o_ctl.ridx      = r_ridx;
        o_ctl.op        = r_op;
        if (r_op == m4te_pkg::ACT_SCALE) begin
            o_ctl.first = 1'b1;
            o_ctl.last  = 1'b1;
        end else begin
            o_ctl.first = (r_step[1:0] == 2'd0);
            o_ctl.last  = (r_step[1:0] == 2'd3);
        end

        if (i_res_vld) begin
            n_ridx = r_ridx + 1'b1;
        end

        case (r_state)
            m4te_pkg::ST_IDLE: begin
                o_ctl.ready = 1'b1;
                if (i_accept) begin
                    if (i_op inside {m4te_pkg::ACT_COMPOSE, m4te_pkg::ACT_SCALE,
                                     m4te_pkg::ACT_XFORM}) begin
                        n_op    = i_op;
                        n_step  = '0;
                        n_ridx  = '0;
                        n_state = m4te_pkg::ST_RUN;
                    end else if (i_op == m4te_pkg::ACT_RD_M) begin
                        n_op    = i_op;
                        n_state = m4te_pkg::ST_DONE;
                    end
                end
            end
            m4te_pkg::ST_RUN: begin
                o_ctl.issue_vld = 1'b1;
                if (r_step == w_last_step) begin
                    n_state = m4te_pkg::ST_DRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            m4te_pkg::ST_DRAIN: begin
                if (i_res_vld && (r_ridx == w_last_res)) begin
                    n_state = (r_op == m4te_pkg::ACT_XFORM) ? m4te_pkg::ST_DONE
                                                            : m4te_pkg::ST_IDLE;
                end
            end
            m4te_pkg::ST_DONE: begin
                o_ctl.load_out = i_out_free;
                if (i_out_free) begin
                    n_state = m4te_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = m4te_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/matrix4_transform_engine_top.sv */
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                              tuser
// s_axis    in   row[1:0] col[3:2] value[35:4] vx[67:36]          action[2:0]
//                vy[99:68] vz[131:100] vw[163:132] zero[167:164]
// m_axis    out  out0[31:0] out1[63:32] out2[95:64] out3[127:96]   saturated[0]
//
// Element writes are taken while idle; a read of M, scale, transform and compose keep the engine
// busy, and a read or transform also waits for a free output.
// Products go through the single multiply-accumulate unit, which takes one product per cycle
// (16 for scale and transform, 64 for compose) and then drains its pipeline.
// Synchronous active-low reset restores M to identity and B to zero.
// s_axis_tready is low while an item is in work; a result waits in the output register
// while m_axis_tready is low, and input is taken again once it is loaded there.

module matrix4_transform_engine_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // row, col, value, vx, vy, vz, vw, zero pad
    input  logic [m4te_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // action
    input  logic [m4te_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out0, out1, out2, out3
    output logic [m4te_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // saturated
    output logic [m4te_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

    localparam int W = m4te_pkg::DATA_W;

    logic signed [W-1:0]            r_m [16];
    logic signed [W-1:0]            r_b [16];
    logic signed [W-1:0]            r_val;
    logic signed [W-1:0]            r_vec [4];
    logic signed [W-1:0]            r_row [4];
    logic signed [W-1:0]            r_res [4];
    logic                           r_sat_acc;
    logic                           r_m_valid;
    logic [m4te_pkg::M_TDATA_W-1:0] r_m_data;
    logic                           r_m_sat;

    m4te_pkg::t_seq_ctl             w_ctl;
    m4te_pkg::t_action              w_in_op;
    logic                           w_accept;
    logic                           w_out_free;
    logic [1:0]                     w_in_row;
    logic [1:0]                     w_in_col;
    logic [m4te_pkg::IDX_W-1:0]     w_in_idx;
    logic signed [W-1:0]            w_in_value;
    logic [m4te_pkg::IDX_W-1:0]     w_a_idx;
    logic signed [W-1:0]            w_a;
    logic signed [W-1:0]            w_b;
    logic                           w_res_vld;
    logic signed [W-1:0]            w_res;
    logic                           w_res_sat;

    assign w_in_op    = m4te_pkg::t_action'(s_axis_tuser);
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_in_row   = s_axis_tdata[1:0];
    assign w_in_col   = s_axis_tdata[3:2];
    assign w_in_idx   = {w_in_row, w_in_col};
    assign w_in_value = s_axis_tdata[35:4];

    m4te_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_op       (w_in_op),
        .i_res_vld  (w_res_vld),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl)
    );

    assign s_axis_tready = w_ctl.ready;

    always_comb begin
        if (w_ctl.op == m4te_pkg::ACT_COMPOSE) begin
            w_a_idx = {w_ctl.step[5:4], w_ctl.step[1:0]};
            w_b     = r_b[{w_ctl.step[1:0], w_ctl.step[3:2]}];
        end else if (w_ctl.op == m4te_pkg::ACT_SCALE) begin
            w_a_idx = w_ctl.step[3:0];
            w_b     = r_val;
        end else begin
            w_a_idx = w_ctl.step[3:0];
            w_b     = r_vec[w_ctl.step[1:0]];
        end
        w_a = r_m[w_a_idx];
    end

    m4te_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_ctl.issue_vld),
        .i_first (w_ctl.first),
        .i_last  (w_ctl.last),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_vld   (w_res_vld),
        .o_res   (w_res),
        .o_sat   (w_res_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int rr = 0; rr < 4; rr++) begin
                for (int cc = 0; cc < 4; cc++) begin
                    r_m[4'(rr * 4 + cc)] <= (rr == cc) ? m4te_pkg::Q_ONE : '0;
                    r_b[4'(rr * 4 + cc)] <= '0;
                end
            end
        end else if (w_accept && (w_in_op == m4te_pkg::ACT_WR_M)) begin
            r_m[w_in_idx] <= w_in_value;
        end else if (w_accept && (w_in_op == m4te_pkg::ACT_WR_B)) begin
            r_b[w_in_idx] <= w_in_value;
        end else if (w_res_vld && (w_ctl.op == m4te_pkg::ACT_SCALE)) begin
            r_m[w_ctl.ridx] <= w_res;
        end else if (w_res_vld && (w_ctl.op == m4te_pkg::ACT_COMPOSE)
                     && (w_ctl.ridx[1:0] == 2'd3)) begin
            r_m[{w_ctl.ridx[3:2], 2'd0}] <= r_row[0];
            r_m[{w_ctl.ridx[3:2], 2'd1}] <= r_row[1];
            r_m[{w_ctl.ridx[3:2], 2'd2}] <= r_row[2];
            r_m[{w_ctl.ridx[3:2], 2'd3}] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val    <= w_in_value;
            r_vec[0] <= s_axis_tdata[67:36];
            r_vec[1] <= s_axis_tdata[99:68];
            r_vec[2] <= s_axis_tdata[131:100];
            r_vec[3] <= s_axis_tdata[163:132];
        end
        if (w_res_vld && (w_ctl.op == m4te_pkg::ACT_COMPOSE)) begin
            r_row[w_ctl.ridx[1:0]] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sat_acc <= 1'b0;
            r_res[0]  <= r_m[w_in_idx];
            r_res[1]  <= '0;
            r_res[2]  <= '0;
            r_res[3]  <= '0;
        end else if (w_res_vld && (w_ctl.op == m4te_pkg::ACT_XFORM)) begin
            r_res[w_ctl.ridx[1:0]] <= w_res;
            r_sat_acc              <= r_sat_acc | w_res_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctl.load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load_out) begin
            r_m_data <= {r_res[3], r_res[2], r_res[1], r_res[0]};
            r_m_sat  <= r_sat_acc;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_sat;

    a_no_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_vld |-> !w_ctl.ready)
        else $error("multiply-accumulate result while sequencer idle");

    a_no_output_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load_out |-> (!r_m_valid || m_axis_tready))
        else $error("output register loaded while a result is pending");

    a_busy_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_in_op == m4te_pkg::ACT_RD_M)) |=> !s_axis_tready)
        else $error("input taken while a read result is being formed");

    a_issue_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.issue_vld |-> (!s_axis_tready && !w_ctl.load_out))
        else $error("product issued outside the run phase");

endmodule

/* tb/sv/matrix4_transform_engine_checker.sv */
`timescale 1ns / 1ps

module matrix4_transform_engine_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // row, col, value, vx, vy, vz, vw, zero pad
    input  logic [m4te_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // action
    input  logic [m4te_pkg::S_TUSER_W-1:0]    i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // out0, out1, out2, out3
    input  logic [m4te_pkg::M_TDATA_W-1:0]    i_m_tdata,
    // saturated
    input  logic [m4te_pkg::M_TUSER_W-1:0]    i_m_tuser,
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_results
);
    import m4te_pkg::*;

    localparam int SUM_W = 70;
    localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(SAT_MAX);
    localparam logic signed [SUM_W-1:0] LIM_LO = SUM_W'(SAT_MIN);

    typedef struct packed {
        logic signed [DATA_W-1:0] out3;
        logic signed [DATA_W-1:0] out2;
        logic signed [DATA_W-1:0] out1;
        logic signed [DATA_W-1:0] out0;
        logic                     clipped;
    } t_vec_result;

    logic signed [DATA_W-1:0] work_m [16];
    logic signed [DATA_W-1:0] oper_b [16];
    t_vec_result              vec_results_q [$];
    int                       err_cnt = 0;
    int                       seen_cnt = 0;

    // exact sum of four products, floor-shifted and clipped; bit DATA_W flags clipping
    function automatic logic [DATA_W:0] q_dot4(
        input logic signed [DATA_W-1:0] a0, a1, a2, a3, b0, b1, b2, b3);
        logic signed [SUM_W-1:0] acc;
        acc = SUM_W'(a0) * SUM_W'(b0) + SUM_W'(a1) * SUM_W'(b1)
            + SUM_W'(a2) * SUM_W'(b2) + SUM_W'(a3) * SUM_W'(b3);
        acc = acc >>> FRAC_BITS;
        if (acc > LIM_HI) return {1'b1, SAT_MAX};
        if (acc < LIM_LO) return {1'b1, SAT_MIN};
        return {1'b0, acc[DATA_W-1:0]};
    endfunction

    task automatic report(input string what, input t_vec_result want, input t_vec_result got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t %s: exp %h %h %h %h sat %b, got %h %h %h %h sat %b", $realtime,
                     what, want.out0, want.out1, want.out2, want.out3, want.clipped,
                     got.out0, got.out1, got.out2, got.out3, got.clipped);
    endtask

    always @(posedge i_clk) begin
        t_vec_result              want;
        t_vec_result              got;
        t_action                  act;
        logic [3:0]               idx;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] vx, vy, vz, vw;
        logic [DATA_W:0]          dot;
        logic signed [DATA_W-1:0] nxt [16];
        int                       r, c;

        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                work_m[i] = (i % 5 == 0) ? Q_ONE : '0;
                oper_b[i] = '0;
            end
            vec_results_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen_cnt++;
                got = {i_m_tdata, i_m_tuser[0]};
                if (vec_results_q.size() == 0) begin
                    want = '0;
                    report("result with nothing pending", want, got);
                end else begin
                    want = vec_results_q.pop_front();
                    if (got.out0 !== want.out0 || got.out1 !== want.out1 ||
                        got.out2 !== want.out2 || got.out3 !== want.out3 ||
                        got.clipped !== want.clipped)
                        report("result mismatch", want, got);
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                act   = t_action'(i_s_tuser[2:0]);
                idx   = {i_s_tdata[1:0], i_s_tdata[3:2]};
                value = i_s_tdata[35:4];
                vx    = i_s_tdata[67:36];
                vy    = i_s_tdata[99:68];
                vz    = i_s_tdata[131:100];
                vw    = i_s_tdata[163:132];
                case (act)
                    ACT_WR_M: work_m[idx] = value;
                    ACT_WR_B: oper_b[idx] = value;
                    ACT_COMPOSE: begin
                        for (int i = 0; i < 16; i++) begin
                            r = i / 4;
                            c = i % 4;
                            dot = q_dot4(work_m[r*4], work_m[r*4+1], work_m[r*4+2],
                                         work_m[r*4+3], oper_b[c], oper_b[4+c],
                                         oper_b[8+c], oper_b[12+c]);
                            nxt[i] = dot[DATA_W-1:0];
                        end
                        for (int i = 0; i < 16; i++) work_m[i] = nxt[i];
                    end
                    ACT_SCALE: begin
                        for (int i = 0; i < 16; i++) begin
                            dot = q_dot4(work_m[i], '0, '0, '0, value, '0, '0, '0);
                            work_m[i] = dot[DATA_W-1:0];
                        end
                    end
                    ACT_XFORM: begin
                        want.clipped = 1'b0;
                        dot = q_dot4(work_m[0], work_m[1], work_m[2], work_m[3],
                                     vx, vy, vz, vw);
                        want.out0 = dot[DATA_W-1:0];
                        want.clipped |= dot[DATA_W];
                        dot = q_dot4(work_m[4], work_m[5], work_m[6], work_m[7],
                                     vx, vy, vz, vw);
                        want.out1 = dot[DATA_W-1:0];
                        want.clipped |= dot[DATA_W];
                        dot = q_dot4(work_m[8], work_m[9], work_m[10], work_m[11],
                                     vx, vy, vz, vw);
                        want.out2 = dot[DATA_W-1:0];
                        want.clipped |= dot[DATA_W];
                        dot = q_dot4(work_m[12], work_m[13], work_m[14], work_m[15],
                                     vx, vy, vz, vw);
                        want.out3 = dot[DATA_W-1:0];
                        want.clipped |= dot[DATA_W];
                        vec_results_q.push_back(want);
                    end
                    ACT_RD_M: begin
                        want = '0;
                        want.out0 = work_m[idx];
                        vec_results_q.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
        o_mismatches <= err_cnt;
        o_results    <= seen_cnt;
        o_pending    <= vec_results_q.size();
    end

endmodule

/* tb/sv/matrix4_transform_engine_top_tb.sv */
`timescale 1ns / 1ps

module matrix4_transform_engine_top_tb;
    import m4te_pkg::*;

    localparam int ITEMS        = 420;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic [S_TUSER_W-1:0]   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;

    int mismatches;
    int pending;
    int results;
    int quiet_cycles = 0;
    int sent_by_act [8];
    int hold_reqs = 0;
    int hold_done = 0;
    bit steady = 1'b0;

    matrix4_transform_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    matrix4_transform_engine_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [1:0] rand2();
        return 2'($urandom());
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return '0;
            3: return Q_ONE;
            4, 5: return $urandom();
            default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    task automatic send_item(input logic [2:0] act, input logic [1:0] row, input logic [1:0] col,
                             input logic [31:0] value, input logic [31:0] vx,
                             input logic [31:0] vy, input logic [31:0] vz,
                             input logic [31:0] vw);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, vw, vz, vy, vx, value, col, row};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_by_act[act]++;
    endtask

    task automatic send_rd(input logic [1:0] row, input logic [1:0] col);
        send_item(ACT_RD_M, row, col, $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom());
    endtask

    task automatic send_wr(input logic [2:0] act, input logic [1:0] row, input logic [1:0] col,
                           input logic [31:0] value);
        send_item(act, row, col, value, $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic send_xform(input logic [31:0] vx, input logic [31:0] vy,
                              input logic [31:0] vz, input logic [31:0] vw);
        send_item(ACT_XFORM, rand2(), rand2(), $urandom(), vx, vy, vz, vw);
    endtask

    // count cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles, %0d results pending",
                     STALL_LIMIT, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int n;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_reqs != hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end
            n = pick_gap();
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge i_clk);
        end
    end

    initial begin
        int counted;
        int unsigned roll;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity after reset, corner indexes and extreme vectors
        send_rd(2'd0, 2'd0);
        send_rd(2'd3, 2'd3);
        send_rd(2'd1, 2'd2);
        send_xform(SAT_MAX, SAT_MIN, '0, 32'hFFFF_FFFF);
        send_wr(ACT_WR_M, 2'd3, 2'd0, SAT_MAX);
        send_wr(ACT_WR_M, 2'd0, 2'd3, SAT_MIN);
        send_xform(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
        send_rd(2'd3, 2'd0);
        send_rd(2'd0, 2'd3);
        send_wr(ACT_WR_B, 2'd0, 2'd0, 32'h0002_0000);
        send_wr(ACT_WR_B, 2'd1, 2'd1, SAT_MIN);
        send_wr(ACT_WR_B, 2'd2, 2'd2, Q_ONE);
        send_wr(ACT_WR_B, 2'd3, 2'd3, SAT_MAX);
        send_item(ACT_COMPOSE, rand2(), rand2(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom());
        send_rd(2'd0, 2'd0);
        send_rd(2'd3, 2'd3);
        // negate: clips the most negative element silently
        send_item(ACT_SCALE, rand2(), rand2(), -Q_ONE, $urandom(), $urandom(),
                  $urandom(), $urandom());
        send_rd(2'd1, 2'd1);
        send_item(ACT_SCALE, rand2(), rand2(), SAT_MAX, $urandom(), $urandom(),
                  $urandom(), $urandom());
        send_xform($urandom(), $urandom(), $urandom(), $urandom());
        send_item(ACT_UNUSED_6, rand2(), rand2(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom());
        send_item(ACT_UNUSED_7, rand2(), rand2(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom());
        send_item(ACT_SCALE, rand2(), rand2(), '0, $urandom(), $urandom(),
                  $urandom(), $urandom());
        send_xform(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_rd(2'd3, 2'd3);

        counted = 0;
        while (counted < ITEMS) begin
            if (counted == 150) hold_reqs++;
            steady = (counted >= 280 && counted < 330);
            roll = $urandom_range(0, 99);
            if (roll < 30)
                send_wr(ACT_WR_M, rand2(), rand2(), rand_q());
            else if (roll < 48)
                send_wr(ACT_WR_B, rand2(), rand2(), rand_q());
            else if (roll < 54)
                send_item(ACT_COMPOSE, rand2(), rand2(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom());
            else if (roll < 60)
                send_item(ACT_SCALE, rand2(), rand2(), rand_q(), $urandom(),
                          $urandom(), $urandom(), $urandom());
            else if (roll < 84)
                send_xform(rand_q(), rand_q(), rand_q(), rand_q());
            else if (roll < 96)
                send_rd(rand2(), rand2());
            else
                send_item($urandom_range(0, 1) ? ACT_UNUSED_6 : ACT_UNUSED_7, rand2(),
                          rand2(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom());
            if (roll < 96) counted++;
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d M writes, %0d B writes, %0d composes, %0d scales, %0d transforms,",
                 sent_by_act[ACT_WR_M], sent_by_act[ACT_WR_B], sent_by_act[ACT_COMPOSE],
                 sent_by_act[ACT_SCALE], sent_by_act[ACT_XFORM]);
        $display("%0d reads and %0d unused codes; %0d results checked, %0d mismatches",
                 sent_by_act[ACT_RD_M], sent_by_act[ACT_UNUSED_6] + sent_by_act[ACT_UNUSED_7],
                 results, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
src/m4te_pkg.sv
src/m4te_mac.sv
src/m4te_seq.sv
src/matrix4_transform_engine_top.sv
tb/sv/matrix4_transform_engine_checker.sv
tb/sv/matrix4_transform_engine_top_tb.sv
